/* hdl/bmp24_sw_pkg.sv */
// ----------------------------------------------------------------------------
// bmp24_sw_pkg
// Shared types, constants and header byte selection for the BMP24 writer.
// ----------------------------------------------------------------------------
package bmp24_sw_pkg;

	localparam int unsigned MAX_DIMENSION  = 20000;
	localparam int unsigned DIM_W          = 15;
	localparam int unsigned HEADER_BYTES   = 54;
	localparam int unsigned INFO_BYTES     = 40;
	localparam int unsigned BITS_PER_PIXEL = 24;
	localparam int unsigned POS_W          = 6;

	// byte positions within one transfer burst
	localparam logic [POS_W-1:0] POS_BLUE  = POS_W'(HEADER_BYTES);
	localparam logic [POS_W-1:0] POS_GREEN = POS_W'(HEADER_BYTES + 1);
	localparam logic [POS_W-1:0] POS_RED   = POS_W'(HEADER_BYTES + 2);

	typedef enum logic [1:0] {
		REG_WIDTH  = 2'd0,
		REG_HEIGHT = 2'd1,
		REG_RES_X  = 2'd2,
		REG_RES_Y  = 2'd3
	} reg_idx_t;

	// per-pixel decisions handed from the counter logic to the serializer
	typedef struct packed {
		logic       hdr;
		logic [1:0] pad;
		logic       img_end;
	} item_ctl_t;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		if (v < DIM_W'(2))
			r = DIM_W'(2);
		else if (v > DIM_W'(MAX_DIMENSION))
			r = DIM_W'(MAX_DIMENSION);
		else
			r = v;
		return r;
	endfunction

	function automatic logic [7:0] hdr_byte(
		input logic [POS_W-1:0] pos,
		input logic [DIM_W-1:0] width,
		input logic [DIM_W-1:0] height,
		input logic [31:0]      res_x,
		input logic [31:0]      res_y,
		input logic [31:0]      array_bytes
	);
		logic [HEADER_BYTES*8-1:0] hdr;
		logic [31:0]               file_size;
		file_size = array_bytes + 32'(HEADER_BYTES);
		// little-endian fields, first byte of the file in the low bits
		hdr = {
			64'd0,
			res_y,
			res_x,
			array_bytes,
			32'd0,
			16'(BITS_PER_PIXEL),
			16'd1,
			{17'd0, height},
			{17'd0, width},
			32'(INFO_BYTES),
			32'(HEADER_BYTES),
			32'd0,
			file_size,
			8'h4D,
			8'h42
		};
		return hdr[pos*8 +: 8];
	endfunction

endpackage

/* hdl/bmp24_sw_ctrl.sv */
// ----------------------------------------------------------------------------
// bmp24_sw_ctrl
// Column and row counters; decides header, padding and image end per pixel.
// ----------------------------------------------------------------------------
module bmp24_sw_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        advance,
	input  logic [bmp24_sw_pkg::DIM_W-1:0] width,
	input  logic [bmp24_sw_pkg::DIM_W-1:0] height,
	output bmp24_sw_pkg::item_ctl_t     ctl
);

	logic [bmp24_sw_pkg::DIM_W-1:0] col_q;
	logic [bmp24_sw_pkg::DIM_W-1:0] row_q;
	logic                           row_end;
	logic                           img_end;

	assign row_end = col_q >= (width - bmp24_sw_pkg::DIM_W'(1));
	assign img_end = row_end && (row_q >= (height - bmp24_sw_pkg::DIM_W'(1)));

	always_comb begin
		ctl.hdr     = (col_q == '0) && (row_q == '0);
		// padding to a multiple of four bytes equals width mod 4 for 3-byte pixels
		ctl.pad     = row_end ? width[1:0] : 2'd0;
		ctl.img_end = img_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (advance) begin
			if (row_end) begin
				col_q <= '0;
				row_q <= img_end ? '0 : row_q + bmp24_sw_pkg::DIM_W'(1);
			end else begin
				col_q <= col_q + bmp24_sw_pkg::DIM_W'(1);
			end
		end
	end

endmodule

/* hdl/bmp24_sw_ser.sv */
// ----------------------------------------------------------------------------
// bmp24_sw_ser
// Holds one pixel and walks its byte burst into the output register.
// ----------------------------------------------------------------------------
module bmp24_sw_ser (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           load,
	input  bmp24_sw_pkg::item_ctl_t        ctl,
	input  logic [7:0]                     red_value,
	input  logic [7:0]                     green_value,
	input  logic [7:0]                     blue_value,
	input  logic [bmp24_sw_pkg::DIM_W-1:0] width,
	input  logic [bmp24_sw_pkg::DIM_W-1:0] height,
	input  logic [31:0]                    res_x,
	input  logic [31:0]                    res_y,
	input  logic [31:0]                    array_bytes,
	output logic                           busy,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [7:0]                     out_byte,
	output logic                           last_of_run,
	output logic                           image_end
);

	logic                           valid_s1;
	logic [7:0]                     red_s1;
	logic [7:0]                     green_s1;
	logic [7:0]                     blue_s1;
	bmp24_sw_pkg::item_ctl_t        ctl_s1;
	logic [bmp24_sw_pkg::POS_W-1:0] pos_s1;

	logic                           valid_s2;
	logic [7:0]                     byte_s2;
	logic                           last_s2;
	logic                           end_s2;

	logic                           step;
	logic [bmp24_sw_pkg::POS_W-1:0] last_pos;
	logic                           at_last;
	logic [7:0]                     byte_sel;

	assign step     = !valid_s2 || !out_stall;
	assign last_pos = bmp24_sw_pkg::POS_RED + bmp24_sw_pkg::POS_W'(ctl_s1.pad);
	assign at_last  = pos_s1 == last_pos;
	// held item stays until its final byte moves into the output register
	assign busy     = valid_s1 && !(step && at_last);

	always_comb begin
		if (pos_s1 < bmp24_sw_pkg::POS_BLUE)
			byte_sel = bmp24_sw_pkg::hdr_byte(pos_s1, width, height, res_x, res_y,
				array_bytes);
		else if (pos_s1 == bmp24_sw_pkg::POS_BLUE)
			byte_sel = blue_s1;
		else if (pos_s1 == bmp24_sw_pkg::POS_GREEN)
			byte_sel = green_s1;
		else if (pos_s1 == bmp24_sw_pkg::POS_RED)
			byte_sel = red_s1;
		else
			byte_sel = 8'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			pos_s1   <= '0;
		end else if (load) begin
			valid_s1 <= 1'b1;
			pos_s1   <= ctl.hdr ? '0 : bmp24_sw_pkg::POS_BLUE;
		end else if (valid_s1 && step) begin
			if (at_last)
				valid_s1 <= 1'b0;
			pos_s1 <= pos_s1 + bmp24_sw_pkg::POS_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			red_s1   <= red_value;
			green_s1 <= green_value;
			blue_s1  <= blue_value;
			ctl_s1   <= ctl;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (step) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step && valid_s1) begin
			byte_s2 <= byte_sel;
			last_s2 <= at_last;
			end_s2  <= at_last && ctl_s1.img_end;
		end
	end

	assign out_valid   = valid_s2;
	assign out_byte    = byte_s2;
	assign last_of_run = last_s2;
	assign image_end   = end_s2;

endmodule

/* hdl/bmp24_stream_writer_unit.sv */
// ----------------------------------------------------------------------------
// bmp24_stream_writer_unit
// Streams an uncompressed 24-bit BMP file, one byte per transfer, from pixels.
// ----------------------------------------------------------------------------
//  channel  | handshake             | payload
//  ---------+-----------------------+----------------------------------------
//  pixel in | in_valid / in_stall   | red_value, green_value, blue_value
//  byte out | out_valid / out_stall | out_byte, last_of_run, image_end
//  config   | wr_en                 | wr_index, wr_data
//
//  A pixel gives one byte per cycle while out_stall is low: 3 pixel bytes,
//  plus 0..3 bytes of row padding, plus 54 header bytes on the first pixel of
//  an image; the single-byte output register sets that rate. The next pixel is
//  taken in the cycle its predecessor's final byte enters the output register.
//  Output stall holds the burst in place and backs up to in_stall. Reset
//  clears the counters and restores width 2, height 2, resolutions 0.
// ----------------------------------------------------------------------------
module bmp24_stream_writer_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  red_value,
	input  logic [7:0]  green_value,
	input  logic [7:0]  blue_value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic        last_of_run,
	output logic        image_end,
	input  logic        wr_en,
	input  logic [1:0]  wr_index,
	input  logic [31:0] wr_data
);

	logic [bmp24_sw_pkg::DIM_W-1:0] width_q;
	logic [bmp24_sw_pkg::DIM_W-1:0] height_q;
	logic [31:0]                    res_x_q;
	logic [31:0]                    res_y_q;
	logic [31:0]                    array_bytes_q;
	logic [16:0]                    row_bytes;

	logic                           busy;
	logic                           load;
	bmp24_sw_pkg::item_ctl_t        ctl;

	assign in_stall = busy;
	assign load     = in_valid && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= bmp24_sw_pkg::DIM_W'(2);
			height_q <= bmp24_sw_pkg::DIM_W'(2);
			res_x_q  <= '0;
			res_y_q  <= '0;
		end else if (wr_en) begin
			unique case (bmp24_sw_pkg::reg_idx_t'(wr_index))
				bmp24_sw_pkg::REG_WIDTH:
					width_q <= bmp24_sw_pkg::clamp_dim(wr_data[bmp24_sw_pkg::DIM_W-1:0]);
				bmp24_sw_pkg::REG_HEIGHT:
					height_q <= bmp24_sw_pkg::clamp_dim(wr_data[bmp24_sw_pkg::DIM_W-1:0]);
				bmp24_sw_pkg::REG_RES_X: res_x_q <= wr_data;
				bmp24_sw_pkg::REG_RES_Y: res_y_q <= wr_data;
				default: ;
			endcase
		end
	end

	// padded row length: 3 bytes a pixel plus width mod 4
	assign row_bytes = {2'd0, width_q} + {1'b0, width_q, 1'b0} + {15'd0, width_q[1:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			array_bytes_q <= 32'd16;
		end else begin
			array_bytes_q <= {15'd0, row_bytes} * {17'd0, height_q};
		end
	end

	bmp24_sw_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.advance(load),
		.width  (width_q),
		.height (height_q),
		.ctl    (ctl)
	);

	bmp24_sw_ser u_ser (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (load),
		.ctl        (ctl),
		.red_value  (red_value),
		.green_value(green_value),
		.blue_value (blue_value),
		.width      (width_q),
		.height     (height_q),
		.res_x      (res_x_q),
		.res_y      (res_y_q),
		.array_bytes(array_bytes_q),
		.busy       (busy),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.last_of_run(last_of_run),
		.image_end  (image_end)
	);

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Feeds pixels into the BMP24 stream writer and checks every output byte
// (file header, pixel bytes, row padding, end-of-pixel and end-of-file flags)
// against an in-bench model of the file stream. Both sides idle at random,
// and registers change between bursts, also in the middle of an image.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int unsigned CYCLE_LIMIT = 1_000_000;

	typedef struct packed {
		logic [7:0] data;
		logic       last_of_run;
		logic       image_end;
	} file_byte_t;

	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        in_valid    = 1'b0;
	logic        in_stall;
	logic [7:0]  red_value   = '0;
	logic [7:0]  green_value = '0;
	logic [7:0]  blue_value  = '0;
	logic        out_valid;
	logic        out_stall   = 1'b0;
	logic [7:0]  out_byte;
	logic        last_of_run;
	logic        image_end;
	logic        wr_en       = 1'b0;
	logic [1:0]  wr_index    = '0;
	logic [31:0] wr_data     = '0;

	// model of the writer's registers and position within the image
	logic [bmp24_sw_pkg::DIM_W-1:0] img_width  = bmp24_sw_pkg::DIM_W'(2);
	logic [bmp24_sw_pkg::DIM_W-1:0] img_height = bmp24_sw_pkg::DIM_W'(2);
	logic [31:0]                    img_res_x  = '0;
	logic [31:0]                    img_res_y  = '0;
	logic [bmp24_sw_pkg::DIM_W-1:0] img_col    = '0;
	logic [bmp24_sw_pkg::DIM_W-1:0] img_row    = '0;

	file_byte_t  file_bytes_due[$];
	int unsigned send_idle_pct = 15;
	int unsigned stall_pct     = 52;
	int unsigned error_count   = 0;
	int unsigned cycle_count   = 0;

	bmp24_stream_writer_unit i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.red_value   (red_value),
		.green_value (green_value),
		.blue_value  (blue_value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_byte    (out_byte),
		.last_of_run (last_of_run),
		.image_end   (image_end),
		.wr_en       (wr_en),
		.wr_index    (wr_index),
		.wr_data     (wr_data)
	);

	always #5 clk = ~clk;

	function automatic logic [bmp24_sw_pkg::DIM_W-1:0] fit_dimension(
		input logic [31:0] raw
	);
		logic [bmp24_sw_pkg::DIM_W-1:0] v;
		v = raw[bmp24_sw_pkg::DIM_W-1:0];
		if (v < bmp24_sw_pkg::DIM_W'(2))
			return bmp24_sw_pkg::DIM_W'(2);
		if (v > bmp24_sw_pkg::DIM_W'(bmp24_sw_pkg::MAX_DIMENSION))
			return bmp24_sw_pkg::DIM_W'(bmp24_sw_pkg::MAX_DIMENSION);
		return v;
	endfunction

	function automatic int unsigned row_pad(input logic [bmp24_sw_pkg::DIM_W-1:0] w);
		int unsigned rem;
		rem = (32'(w) * 3) & 3;
		return (rem == 0) ? 0 : 4 - rem;
	endfunction

	function automatic void flag_error(input string msg);
		error_count++;
		if (error_count <= 10)
			$display("%0t: %s", $realtime, msg);
	endfunction

	task automatic queue_le(input logic [31:0] value, input int unsigned count);
		for (int unsigned i = 0; i < count; i++)
			file_bytes_due.push_back('{data: value[8*i +: 8], last_of_run: 1'b0,
				image_end: 1'b0});
	endtask

	task automatic predict_pixel_bytes(input logic [7:0] r, g, b);
		logic [31:0] array_bytes;
		file_byte_t  tail;
		logic        file_done;
		file_done = 1'b0;
		if (img_col == 0 && img_row == 0) begin
			array_bytes = (32'(img_width) * 3 + row_pad(img_width)) * 32'(img_height);
			queue_le(32'h4D42, 2);
			queue_le(array_bytes + bmp24_sw_pkg::HEADER_BYTES, 4);
			queue_le(32'd0, 4);
			queue_le(bmp24_sw_pkg::HEADER_BYTES, 4);
			queue_le(bmp24_sw_pkg::INFO_BYTES, 4);
			queue_le(32'(img_width), 4);
			queue_le(32'(img_height), 4);
			queue_le(32'd1, 2);
			queue_le(bmp24_sw_pkg::BITS_PER_PIXEL, 2);
			queue_le(32'd0, 4);
			queue_le(array_bytes, 4);
			queue_le(img_res_x, 4);
			queue_le(img_res_y, 4);
			queue_le(32'd0, 4);
			queue_le(32'd0, 4);
		end
		queue_le(32'(b), 1);
		queue_le(32'(g), 1);
		queue_le(32'(r), 1);
		// live register values decide where rows and images end
		if (img_col >= img_width - 1'b1) begin
			repeat (row_pad(img_width))
				queue_le(32'd0, 1);
			img_col = '0;
			if (img_row >= img_height - 1'b1) begin
				file_done = 1'b1;
				img_row   = '0;
			end else begin
				img_row = img_row + 1'b1;
			end
		end else begin
			img_col = img_col + 1'b1;
		end
		tail = file_bytes_due.pop_back();
		tail.last_of_run = 1'b1;
		tail.image_end   = file_done;
		file_bytes_due.push_back(tail);
	endtask

	task automatic send_pixel(input logic [7:0] r, g, b);
		bit taken;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		red_value   <= r;
		green_value <= g;
		blue_value  <= b;
		do begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end while (!taken);
		predict_pixel_bytes(r, g, b);
	endtask

	// drop valid and wait until every predicted byte has been taken
	task automatic drain_output();
		in_valid <= 1'b0;
		while (file_bytes_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_config(input logic [31:0] width_raw, height_raw, res_x, res_y);
		wr_en    <= 1'b1;
		wr_index <= bmp24_sw_pkg::REG_WIDTH;
		wr_data  <= width_raw;
		@(posedge clk);
		wr_index <= bmp24_sw_pkg::REG_HEIGHT;
		wr_data  <= height_raw;
		@(posedge clk);
		wr_index <= bmp24_sw_pkg::REG_RES_X;
		wr_data  <= res_x;
		@(posedge clk);
		wr_index <= bmp24_sw_pkg::REG_RES_Y;
		wr_data  <= res_y;
		@(posedge clk);
		wr_en      <= 1'b0;
		img_width  = fit_dimension(width_raw);
		img_height = fit_dimension(height_raw);
		img_res_x  = res_x;
		img_res_y  = res_y;
	endtask

	// reset dimensions: 2x2 image with two pad bytes per row
	task automatic test_default_image();
		send_pixel(8'h00, 8'h00, 8'h00);
		send_pixel(8'hFF, 8'hFF, 8'hFF);
		send_pixel(8'hA5, 8'h5A, 8'h0F);
		send_pixel(8'h80, 8'h01, 8'h7E);
	endtask

	// clamped maximum dimensions in the header, then a shrink mid-row
	task automatic test_dimension_limits();
		drain_output();
		set_config(32'h0000_7FFF, 32'd20001, 32'hFFFF_FFFF, 32'h8000_0001);
		send_pixel(8'h12, 8'h34, 8'h56);
		send_pixel(8'hFE, 8'h7F, 8'h01);
		send_pixel(8'h55, 8'hAA, 8'hC3);
		drain_output();
		// column already past the new width: the next pixel ends the row
		set_config(32'd0, 32'hFFFF_0001, 32'd0, 32'h0000_0001);
		send_pixel(8'h01, 8'h02, 8'h03);
		send_pixel(8'hF0, 8'h0F, 8'h99);
		send_pixel(8'h7F, 8'h80, 8'hFF);
	endtask

	// height cut below the current row while an image is in progress
	task automatic test_live_resize();
		drain_output();
		set_config(32'd3, 32'd20000, 32'd72, 32'd96);
		repeat (6)
			send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
		drain_output();
		set_config(32'd3, 32'd1, 32'd2835, 32'd2835);
		repeat (3)
			send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
	endtask

	task automatic test_random_images(input int unsigned item_goal);
		int unsigned sent;
		int unsigned pick;
		logic [31:0] width_raw;
		logic [31:0] height_raw;
		logic [31:0] res_x;
		logic [31:0] res_y;
		sent = 0;
		while (sent < item_goal) begin
			pick = $urandom_range(99);
			if (pick < 70)
				width_raw = $urandom_range(9, 2);
			else if (pick < 82)
				width_raw = $urandom_range(40, 10);
			else if (pick < 88)
				width_raw = $urandom_range(1, 0);
			else if (pick < 94)
				width_raw = $urandom_range(32767, 20001);
			else
				width_raw = $urandom_range(9, 2) | ($urandom & 32'hFFFF_8000);
			pick = $urandom_range(99);
			if (pick < 80)
				height_raw = $urandom_range(5, 2);
			else if (pick < 90)
				height_raw = $urandom_range(1, 0);
			else
				height_raw = $urandom;
			pick  = $urandom_range(99);
			res_x = (pick < 10) ? 32'd0 : (pick < 20) ? 32'hFFFF_FFFF : $urandom;
			pick  = $urandom_range(99);
			res_y = (pick < 10) ? 32'd0 : (pick < 20) ? 32'hFFFF_FFFF : $urandom;
			drain_output();
			set_config(width_raw, height_raw, res_x, res_y);
			repeat ($urandom_range(30, 4)) begin
				send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
				sent++;
			end
			// mostly finish the image so the next burst starts with a header
			if ($urandom_range(2) != 0 && 32'(img_width) * 32'(img_height) <= 200) begin
				while (img_col != 0 || img_row != 0) begin
					send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
					sent++;
				end
			end
		end
	endtask

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// a byte is transferred at the next rising edge when valid and not stalled
	always @(negedge clk) begin : check_bytes
		file_byte_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (file_bytes_due.size() == 0) begin
				flag_error($sformatf("unexpected byte %02h last_of_run=%0b image_end=%0b",
					out_byte, last_of_run, image_end));
			end else begin
				want = file_bytes_due.pop_front();
				if (out_byte !== want.data || last_of_run !== want.last_of_run ||
						image_end !== want.image_end) begin
					flag_error($sformatf({"byte mismatch: expected %02h/%0b/%0b, ",
						"got %02h/%0b/%0b (byte/last_of_run/image_end)"},
						want.data, want.last_of_run, want.image_end,
						out_byte, last_of_run, image_end));
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[bmp24_stream_writer_unit] ERROR");
			$finish;
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_image();
		test_dimension_limits();
		test_live_resize();
		send_idle_pct = 15;
		stall_pct     = 52;
		test_random_images(145);
		send_idle_pct = 52;
		stall_pct     = 15;
		test_random_images(145);
		send_idle_pct = 0;
		stall_pct     = 0;
		test_random_images(145);
		drain_output();
		repeat (60) @(posedge clk);
		if (error_count == 0 && file_bytes_due.size() == 0)
			$display("[bmp24_stream_writer_unit] OK");
		else
			$display("[bmp24_stream_writer_unit] ERROR");
		$finish;
	end

endmodule

/* files.f */
hdl/bmp24_sw_pkg.sv
hdl/bmp24_sw_ctrl.sv
hdl/bmp24_sw_ser.sv
hdl/bmp24_stream_writer_unit.sv
tb/tb_top.sv
